>>> sv/mrot_pkg.sv
// shared types, codes and sizes for the memory region ownership table
package mrot_pkg;

  localparam int REGION_COUNT = 64;
  localparam int IDX_W        = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [2:0]       mode_t;
  typedef logic [1:0]       status_t;
  typedef logic [1:0]       life_t;
  typedef logic [1:0]       kind_t;
  typedef logic [1:0]       bit_op_t;
  typedef logic [63:0]      word_t;

  localparam mode_t MODE_QSTATE = 3'd0;
  localparam mode_t MODE_QOWNER = 3'd1;
  localparam mode_t MODE_ASSIGN = 3'd2;
  localparam mode_t MODE_BLOCK  = 3'd3;
  localparam mode_t MODE_FREE   = 3'd4;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_INVAL  = 2'd1;
  localparam status_t ST_ISTATE = 2'd2;
  localparam status_t ST_DENIED = 2'd3;

  localparam life_t LIFE_FREE    = 2'd0;
  localparam life_t LIFE_OWNED   = 2'd1;
  localparam life_t LIFE_BLOCKED = 2'd2;

  localparam kind_t KIND_NONE    = 2'd0;
  localparam kind_t KIND_OS      = 2'd1;
  localparam kind_t KIND_ENCLAVE = 2'd2;

  localparam bit_op_t OP_NONE  = 2'd0;
  localparam bit_op_t OP_SET   = 2'd1;
  localparam bit_op_t OP_CLEAR = 2'd2;

  typedef struct packed {
    life_t life;
    kind_t kind;
    word_t id;
  } entry_t;

  typedef struct packed {
    logic   en;
    idx_t   addr;
    entry_t data;
  } tbl_wr_t;

  typedef struct packed {
    status_t status;
    life_t   life;
    word_t   owner;
    word_t   os_bitmap;
    bit_op_t bit_op;
    word_t   target;
  } result_t;

endpackage

>>> sv/mrot_table.sv
// region entry memory with per-entry valid bits and write-to-read bypass
module mrot_table (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  mrot_pkg::idx_t   rd_addr,
  input  mrot_pkg::tbl_wr_t wr,
  output mrot_pkg::entry_t rd_entry
);
  import mrot_pkg::*;

  entry_t                  mem [REGION_COUNT];
  logic [REGION_COUNT-1:0] vld_r;
  logic                    hit_r;
  logic                    rvld_r;
  entry_t                  rd_raw_r;
  entry_t                  byp_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      hit_r  <= 1'b0;
      rvld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        hit_r  <= wr.en && (wr.addr == rd_addr);
        rvld_r <= vld_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_raw_r   <= mem[rd_addr];
      byp_data_r <= wr.data;
    end
  end

  // never-written entries read as the reset value (all zero)
  assign rd_entry = hit_r ? byp_data_r : (rvld_r ? rd_raw_r : '0);

endmodule

>>> sv/mrot_cmd.sv
// command checks and state update for one region command
module mrot_cmd (
  input  mrot_pkg::mode_t   mode,
  input  logic [7:0]        region,
  input  mrot_pkg::word_t   req_owner,
  input  logic              owner_valid,
  input  logic              owner_initialized,
  input  mrot_pkg::entry_t  entry,
  input  mrot_pkg::word_t   os_bitmap,
  output logic              wr_en,
  output mrot_pkg::entry_t  entry_nxt,
  output mrot_pkg::word_t   os_bitmap_nxt,
  output mrot_pkg::result_t res
);
  import mrot_pkg::*;

  logic  in_range;
  logic  encl;
  idx_t  idx;
  word_t bit_sel;

  assign in_range = region < 8'(REGION_COUNT);
  assign encl     = req_owner != '0;
  assign idx      = region[IDX_W-1:0];
  assign bit_sel  = 64'(1) << idx;

  always_comb begin
    wr_en         = 1'b0;
    entry_nxt     = entry;
    os_bitmap_nxt = os_bitmap;
    res.status    = ST_OK;
    res.life      = LIFE_FREE;
    res.owner     = '0;
    res.bit_op    = OP_NONE;
    res.target    = '0;
    if (!in_range) begin
      res.status = ST_INVAL;
    end else begin
      case (mode)
        MODE_QSTATE: begin
          res.life = entry.life;
        end
        MODE_QOWNER: begin
          res.owner = entry.id;
        end
        MODE_ASSIGN: begin
          if (encl && !owner_valid) begin
            res.status = ST_INVAL;
          end else if (encl && owner_initialized) begin
            res.status = ST_ISTATE;
          end else if (entry.life != LIFE_FREE) begin
            res.status = ST_ISTATE;
          end else begin
            wr_en          = 1'b1;
            entry_nxt.life = LIFE_OWNED;
            if (encl) begin
              entry_nxt.kind = KIND_ENCLAVE;
              entry_nxt.id   = req_owner;
              res.bit_op     = OP_SET;
              res.target     = req_owner;
            end else begin
              entry_nxt.kind = KIND_OS;
              entry_nxt.id   = '0;
              os_bitmap_nxt  = os_bitmap | bit_sel;
            end
          end
        end
        MODE_BLOCK: begin
          if (entry.life != LIFE_OWNED) begin
            res.status = ST_ISTATE;
          end else if (entry.kind != KIND_OS) begin
            res.status = ST_DENIED;
          end else begin
            wr_en          = 1'b1;
            entry_nxt.life = LIFE_BLOCKED;
          end
        end
        MODE_FREE: begin
          if (entry.life != LIFE_BLOCKED) begin
            res.status = ST_ISTATE;
          end else begin
            wr_en          = 1'b1;
            entry_nxt.life = LIFE_FREE;
            if (entry.kind == KIND_OS) begin
              os_bitmap_nxt = os_bitmap & ~bit_sel;
            end else if (entry.kind == KIND_ENCLAVE) begin
              res.bit_op = OP_CLEAR;
              res.target = entry.id;
            end
          end
        end
        default: begin
          res.status = ST_INVAL;
        end
      endcase
    end
    res.os_bitmap = os_bitmap_nxt;
  end

endmodule

>>> sv/memory_region_ownership_table_unit.sv
// Memory region ownership table: one command (query state, query owner, assign, block,
// free) per transfer on the in_ channel, one result per command on the out_ channel.
// A command is registered together with its region entry, read from the entry memory
// at acceptance, and its result moves from there into the output register; a new command
// can be accepted every cycle while no stalled result holds the pipeline; the throughput
// is set by the single write port of the entry memory, which takes one update a cycle,
// with a bypass for a command that reads the region the previous command writes.
// Every entry reads as free, no owner after reset, with no clearing pass.
module memory_region_ownership_table_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mrot_pkg::mode_t     in_mode,
  input  logic [7:0]          in_region,
  input  mrot_pkg::word_t     in_req_owner,
  input  logic                in_owner_valid,
  input  logic                in_owner_initialized,
  output logic                out_valid,
  input  logic                out_stall,
  output mrot_pkg::status_t   out_status,
  output mrot_pkg::life_t     out_region_life,
  output mrot_pkg::word_t     out_owner_out,
  output mrot_pkg::word_t     out_os_bitmap_out,
  output mrot_pkg::bit_op_t   out_enclave_bit_op,
  output mrot_pkg::word_t     out_enclave_target
);
  import mrot_pkg::*;

  logic       s1_vld_r;
  logic       s2_vld_r;
  mode_t      mode_r;
  logic [7:0] region_r;
  word_t      req_owner_r;
  logic       owner_valid_r;
  logic       owner_init_r;
  word_t      os_bitmap_r;
  result_t    res_r;

  logic       in_xfer;
  logic       s1_fire;
  entry_t     entry;
  entry_t     entry_nxt;
  word_t      os_bitmap_nxt;
  logic       cmd_wr;
  result_t    res;
  tbl_wr_t    tbl_wr;

  assign s1_fire  = s1_vld_r && !(s2_vld_r && out_stall);
  assign in_stall = s1_vld_r && !s1_fire;
  assign in_xfer  = in_valid && !in_stall;

  assign tbl_wr.en   = s1_fire && cmd_wr;
  assign tbl_wr.addr = region_r[IDX_W-1:0];
  assign tbl_wr.data = entry_nxt;

  mrot_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_xfer),
    .rd_addr  (in_region[IDX_W-1:0]),
    .wr       (tbl_wr),
    .rd_entry (entry)
  );

  mrot_cmd u_cmd (
    .mode              (mode_r),
    .region            (region_r),
    .req_owner         (req_owner_r),
    .owner_valid       (owner_valid_r),
    .owner_initialized (owner_init_r),
    .entry             (entry),
    .os_bitmap         (os_bitmap_r),
    .wr_en             (cmd_wr),
    .entry_nxt         (entry_nxt),
    .os_bitmap_nxt     (os_bitmap_nxt),
    .res               (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      os_bitmap_r <= '0;
    end else begin
      if (in_xfer) begin
        s1_vld_r <= 1'b1;
      end else if (s1_fire) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_fire) begin
        s2_vld_r    <= 1'b1;
        os_bitmap_r <= os_bitmap_nxt;
      end else if (!out_stall) begin
        s2_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r        <= in_mode;
      region_r      <= in_region;
      req_owner_r   <= in_req_owner;
      owner_valid_r <= in_owner_valid;
      owner_init_r  <= in_owner_initialized;
    end
    if (s1_fire) begin
      res_r <= res;
    end
  end

  assign out_valid          = s2_vld_r;
  assign out_status         = res_r.status;
  assign out_region_life    = res_r.life;
  assign out_owner_out      = res_r.owner;
  assign out_os_bitmap_out  = res_r.os_bitmap;
  assign out_enclave_bit_op = res_r.bit_op;
  assign out_enclave_target = res_r.target;

endmodule

>>> sv/mrot_checker.sv
// port-level checks for the memory region ownership table and their bind
module mrot_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input mrot_pkg::status_t out_status,
  input mrot_pkg::life_t   out_region_life,
  input mrot_pkg::word_t   out_owner_out,
  input mrot_pkg::word_t   out_os_bitmap_out,
  input mrot_pkg::bit_op_t out_enclave_bit_op,
  input mrot_pkg::word_t   out_enclave_target
);
  import mrot_pkg::*;

  // stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_os_bitmap_out) && $stable(out_enclave_target))
    else $error("stalled result changed");

  // failed command reports no life or owner and requests no bitmap update
  a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_enclave_bit_op == OP_NONE)
      && (out_region_life == LIFE_FREE) && (out_owner_out == '0))
    else $error("failed command has side results");

  // no request means no target
  a_no_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_enclave_bit_op == OP_NONE) |-> out_enclave_target == '0)
    else $error("target without request");

  // a set request always names an enclave
  a_set_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_enclave_bit_op == OP_SET) |-> out_enclave_target != '0)
    else $error("set request for owner zero");

endmodule

bind memory_region_ownership_table_unit mrot_checker u_mrot_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_status         (out_status),
  .out_region_life    (out_region_life),
  .out_owner_out      (out_owner_out),
  .out_os_bitmap_out  (out_os_bitmap_out),
  .out_enclave_bit_op (out_enclave_bit_op),
  .out_enclave_target (out_enclave_target)
);

>>> tb/tb_memory_region_ownership_table_unit.sv
// self-checking testbench for the memory region ownership table unit
module tb_memory_region_ownership_table_unit;
  import mrot_pkg::*;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] region;
    word_t      req_owner;
    logic       owner_valid;
    logic       owner_initialized;
  } cmd_t;

  localparam int CMD_TARGET = 700;
  localparam int QUIET_TAIL = 100;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  mode_t      in_mode = MODE_QSTATE;
  logic [7:0] in_region = '0;
  word_t      in_req_owner = '0;
  logic       in_owner_valid = 1'b0;
  logic       in_owner_initialized = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  status_t    out_status;
  life_t      out_region_life;
  word_t      out_owner_out;
  word_t      out_os_bitmap_out;
  bit_op_t    out_enclave_bit_op;
  word_t      out_enclave_target;

  cmd_t    pending_cmds[$];
  result_t expected_results[$];

  life_t tbl_life  [REGION_COUNT];
  kind_t tbl_kind  [REGION_COUNT];
  word_t tbl_owner [REGION_COUNT];
  word_t os_map;

  int   errors = 0;
  int   total_cmds = 0;
  int   results_seen = 0;
  int   in_gap = 0;
  int   out_gap = 0;
  int   idle_cycles = 0;
  logic in_fired = 1'b0;

  memory_region_ownership_table_unit DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_mode              (in_mode),
    .in_region            (in_region),
    .in_req_owner         (in_req_owner),
    .in_owner_valid       (in_owner_valid),
    .in_owner_initialized (in_owner_initialized),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_region_life      (out_region_life),
    .out_owner_out        (out_owner_out),
    .out_os_bitmap_out    (out_os_bitmap_out),
    .out_enclave_bit_op   (out_enclave_bit_op),
    .out_enclave_target   (out_enclave_target)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic result_t apply_ownership_cmd(cmd_t c);
    result_t r;
    int      idx;
    logic    encl;
    r = '0;
    if (c.mode > MODE_FREE || c.region >= REGION_COUNT) begin
      r.status = ST_INVAL;
    end else begin
      idx  = int'(c.region);
      encl = (c.req_owner != '0);
      case (c.mode)
        MODE_QSTATE: r.life = tbl_life[idx];
        MODE_QOWNER: r.owner = tbl_owner[idx];
        MODE_ASSIGN: begin
          if (encl && !c.owner_valid) begin
            r.status = ST_INVAL;
          end else if (encl && c.owner_initialized) begin
            r.status = ST_ISTATE;
          end else if (tbl_life[idx] != LIFE_FREE) begin
            r.status = ST_ISTATE;
          end else begin
            if (encl) begin
              r.bit_op       = OP_SET;
              r.target       = c.req_owner;
              tbl_owner[idx] = c.req_owner;
              tbl_kind[idx]  = KIND_ENCLAVE;
            end else begin
              os_map[idx]    = 1'b1;
              tbl_owner[idx] = '0;
              tbl_kind[idx]  = KIND_OS;
            end
            tbl_life[idx] = LIFE_OWNED;
          end
        end
        MODE_BLOCK: begin
          if (tbl_life[idx] != LIFE_OWNED) begin
            r.status = ST_ISTATE;
          end else if (tbl_kind[idx] != KIND_OS) begin
            r.status = ST_DENIED;
          end else begin
            tbl_life[idx] = LIFE_BLOCKED;
          end
        end
        default: begin
          if (tbl_life[idx] != LIFE_BLOCKED) begin
            r.status = ST_ISTATE;
          end else begin
            if (tbl_kind[idx] == KIND_OS) begin
              os_map[idx] = 1'b0;
            end else if (tbl_kind[idx] == KIND_ENCLAVE) begin
              r.bit_op = OP_CLEAR;
              r.target = tbl_owner[idx];
            end
            tbl_life[idx] = LIFE_FREE;
          end
        end
      endcase
    end
    r.os_bitmap = os_map;
    return r;
  endfunction

  task automatic add_cmd(mode_t m, logic [7:0] rg, word_t own, logic v, logic ini);
    cmd_t c;
    c = '{mode: m, region: rg, req_owner: own, owner_valid: v, owner_initialized: ini};
    pending_cmds.push_back(c);
  endtask

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic check_field(string fname, word_t want, word_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      errors++;
    end
  endtask

  always @(negedge clk) begin : cmd_driver
    if (rst_n && !(in_valid && !in_fired)) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (pending_cmds.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        in_gap = $urandom_range(0, 3);
      end else if (pending_cmds.size() > 0) begin
        in_valid             <= 1'b1;
        in_mode              <= pending_cmds[0].mode;
        in_region            <= pending_cmds[0].region;
        in_req_owner         <= pending_cmds[0].req_owner;
        in_owner_valid       <= pending_cmds[0].owner_valid;
        in_owner_initialized <= pending_cmds[0].owner_initialized;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : result_stall
    if (out_gap > 0) begin
      out_stall <= 1'b1;
      out_gap--;
    end else if (results_seen < total_cmds - QUIET_TAIL && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      out_gap = $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : scoreboard
    cmd_t    c;
    result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        c = '{mode: in_mode, region: in_region, req_owner: in_req_owner,
              owner_valid: in_owner_valid, owner_initialized: in_owner_initialized};
        expected_results.push_back(apply_ownership_cmd(c));
        void'(pending_cmds.pop_front());
      end
      in_fired <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %h",
                   $time, out_status);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", word_t'(want.status), word_t'(out_status));
          check_field("region_life", word_t'(want.life), word_t'(out_region_life));
          check_field("owner_out", want.owner, out_owner_out);
          check_field("os_bitmap_out", want.os_bitmap, out_os_bitmap_out);
          check_field("enclave_bit_op", word_t'(want.bit_op), word_t'(out_enclave_bit_op));
          check_field("enclave_target", want.target, out_enclave_target);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    int         pick;
    logic [7:0] rg;
    word_t      own;
    for (int i = 0; i < REGION_COUNT; i++) begin
      tbl_life[i]  = LIFE_FREE;
      tbl_kind[i]  = KIND_NONE;
      tbl_owner[i] = '0;
    end
    os_map = '0;

    add_cmd(MODE_QSTATE, 8'd0, '0, 1'b0, 1'b0);
    add_cmd(MODE_QOWNER, 8'd63, '0, 1'b0, 1'b0);
    // os owner ignores the enclave flags
    add_cmd(MODE_ASSIGN, 8'd0, '0, 1'b1, 1'b1);
    add_cmd(MODE_QSTATE, 8'd0, '1, 1'b1, 1'b1);
    add_cmd(MODE_ASSIGN, 8'd0, '0, 1'b0, 1'b0);
    add_cmd(MODE_ASSIGN, 8'd63, '1, 1'b1, 1'b0);
    add_cmd(MODE_QOWNER, 8'd63, '0, 1'b0, 1'b0);
    add_cmd(MODE_ASSIGN, 8'd62, 64'd7, 1'b0, 1'b0);
    add_cmd(MODE_ASSIGN, 8'd62, 64'd7, 1'b1, 1'b1);
    add_cmd(MODE_ASSIGN, 8'd62, 64'd7, 1'b0, 1'b1);
    add_cmd(MODE_BLOCK, 8'd63, '0, 1'b0, 1'b0);
    add_cmd(MODE_BLOCK, 8'd5, '0, 1'b0, 1'b0);
    add_cmd(MODE_BLOCK, 8'd0, '0, 1'b0, 1'b0);
    add_cmd(MODE_QSTATE, 8'd0, '0, 1'b0, 1'b0);
    add_cmd(MODE_ASSIGN, 8'd0, '0, 1'b0, 1'b0);
    add_cmd(MODE_FREE, 8'd63, '0, 1'b0, 1'b0);
    add_cmd(MODE_FREE, 8'd0, '0, 1'b0, 1'b0);
    // owner query after an os region is freed
    add_cmd(MODE_QOWNER, 8'd0, '0, 1'b0, 1'b0);
    add_cmd(MODE_FREE, 8'd0, '0, 1'b0, 1'b0);
    add_cmd(3'd5, 8'd0, '0, 1'b0, 1'b0);
    add_cmd(3'd7, 8'd1, '1, 1'b1, 1'b1);
    add_cmd(MODE_QSTATE, 8'd64, '0, 1'b0, 1'b0);
    add_cmd(MODE_ASSIGN, 8'd255, '0, 1'b0, 1'b0);
    add_cmd(MODE_ASSIGN, 8'd62, 64'd1, 1'b1, 1'b0);
    add_cmd(MODE_QSTATE, 8'd62, '0, 1'b0, 1'b0);

    while (pending_cmds.size() < CMD_TARGET) begin
      pick = $urandom_range(0, 9);
      rg   = 8'($urandom_range(0, REGION_COUNT - 1));
      if (pick < 6) begin
        // os region through its whole life cycle
        add_cmd(MODE_ASSIGN, rg, '0, rand_bit(), rand_bit());
        if ($urandom_range(0, 1)) add_cmd(MODE_QSTATE, rg, rand_word(), 1'b0, 1'b0);
        add_cmd(MODE_BLOCK, rg, rand_word(), rand_bit(), 1'b0);
        if ($urandom_range(0, 1)) add_cmd(MODE_QOWNER, rg, '0, 1'b0, 1'b0);
        add_cmd(MODE_FREE, rg, '0, 1'b0, rand_bit());
        if ($urandom_range(0, 2) == 0) add_cmd(MODE_QSTATE, rg, '0, 1'b0, 1'b0);
      end else if (pick < 7) begin
        own = rand_word();
        if (own == '0) own = 64'd1;
        add_cmd(MODE_ASSIGN, rg, own, rand_bit(), rand_bit());
        add_cmd(MODE_QOWNER, rg, '0, 1'b0, 1'b0);
      end else begin
        add_cmd(mode_t'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), rand_word(),
                rand_bit(), rand_bit());
      end
    end
    total_cmds = pending_cmds.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results missing", $time, expected_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/mrot_pkg.sv
sv/mrot_table.sv
sv/mrot_cmd.sv
sv/memory_region_ownership_table_unit.sv
sv/mrot_checker.sv
tb/tb_memory_region_ownership_table_unit.sv
